/* hw/rtl/vdh_pkg.sv */
// vdh_pkg: shared constants, codes and key helper functions of the vertex
// dedup hash table; no dependencies
package vdh_pkg;

	localparam int MAX_ENTRIES = 1024;
	localparam int MAX_SLOTS   = 2048;
	localparam int FRAC_BITS   = 16;
	localparam int NUM_FIELDS  = 8;
	localparam int KEY_TERMS   = 5;

	localparam int FLD_W   = 32;
	localparam int IDX_W   = $clog2(MAX_ENTRIES);
	localparam int CNT_W   = IDX_W + 1;
	localparam int SLOT_W  = $clog2(MAX_SLOTS);
	localparam int K_W     = $clog2(NUM_FIELDS);
	localparam int FADDR_W = IDX_W + K_W;
	localparam int SUM_W   = 41;
	localparam int MAG_W   = SUM_W - FRAC_BITS;
	localparam int DIV_W   = $clog2(MAG_W);

	localparam int SC_W  = 12;
	localparam int TOL_W = 16;
	localparam int CFG_W = 16;

	localparam logic [SC_W-1:0]  SLOT_COUNT_RST = SC_W'(MAX_SLOTS);
	localparam logic [TOL_W-1:0] TOLERANCE_RST  = TOL_W'(66);

	typedef enum logic {
		CFG_SLOT_COUNT = 1'b0,
		CFG_TOLERANCE  = 1'b1
	} cfg_index_t;

	// link / head entry: valid flag plus vertex index
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
	} ptr_t;

	// key term order: x, y, z, s, t
	function automatic logic [K_W-1:0] key_field(input logic [K_W-1:0] sel);
		logic [K_W-1:0] r;
		case (sel)
			3'd0: r = 3'd0;
			3'd1: r = 3'd1;
			3'd2: r = 3'd2;
			3'd3: r = 3'd6;
			default: r = 3'd7;
		endcase
		return r;
	endfunction

	function automatic logic signed [SUM_W-1:0] key_term(input logic signed [FLD_W-1:0] f,
			input logic [K_W-1:0] sel);
		logic signed [SUM_W-1:0] fx;
		logic signed [SUM_W-1:0] c;
		fx = SUM_W'(f);
		case (sel)
			3'd0: c = SUM_W'(10);
			3'd1: c = SUM_W'(100);
			3'd2: c = SUM_W'(112);
			3'd3: c = SUM_W'(123);
			default: c = SUM_W'(42);
		endcase
		return fx * c;
	endfunction

endpackage

/* hw/rtl/vdh_ram.sv */
// vdh_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module vdh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* hw/rtl/vertex_dedup_hash_table_unit.sv */
// vertex_dedup_hash_table_unit: vertex welding hash table, top level
// depends on vdh_pkg and vdh_ram
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  s_tdata: eight signed q16.16 vertex fields
// m_*      out  m_tvalid/m_tready  m_tdata: vertex_index; m_tuser: was_new, table_full
// cfg_*    in   cfg_valid/cfg_ready cfg_index selects register, cfg_data value
//
// sequence: the slot key (accumulate, magnitude, restoring modulo steps,
//   head read), then a field read and compare per field compared and a
//   link read per chain link, then an append; the single field compare unit
//   and the single read port of the field ram set the per-entry cost
// reset: a pass over all slots clears the slot heads; no transaction is taken
//   meanwhile, configuration writes always are
// stalls: one vertex at a time; the result register lets the next vertex
//   in while the previous result waits on m_tready
module vertex_dedup_hash_table_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [8*vdh_pkg::FLD_W-1:0] s_tdata,  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_s, tex_t
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [15:0]                m_tdata,   // vertex_index, zero fill
	output logic [1:0]                 m_tuser,   // was_new, table_full
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_index,
	input  logic [vdh_pkg::CFG_W-1:0]  cfg_data
);
	import vdh_pkg::*;

	typedef enum logic [15:0] {
		S_CLEAR = 16'h0001,
		S_IDLE  = 16'h0002,
		S_KEY   = 16'h0004,
		S_ABS   = 16'h0008,
		S_DIV   = 16'h0010,
		S_HRD   = 16'h0020,
		S_HWT   = 16'h0040,
		S_FRD   = 16'h0080,
		S_FCMP  = 16'h0100,
		S_LRD   = 16'h0200,
		S_LWT   = 16'h0400,
		S_APP   = 16'h0800,
		S_WFLD  = 16'h1000,
		S_WLNK  = 16'h2000,
		S_WTAIL = 16'h4000,
		S_DONE  = 16'h8000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [SC_W-1:0]  slot_count_q;
	logic [TOL_W-1:0] tol_q;

	// working registers of the current vertex
	logic signed [FLD_W-1:0] fld_q [NUM_FIELDS];
	logic signed [SUM_W-1:0] acc_q;
	logic [MAG_W-1:0]        mag_q;
	logic [SLOT_W-1:0]       rem_q;
	logic [K_W-1:0]          k_q;
	logic [DIV_W-1:0]        dc_q;
	logic [SLOT_W-1:0]       clr_q;
	logic [IDX_W-1:0]        cur_q;
	logic [IDX_W-1:0]        tail_q;
	logic                    have_tail_q;
	logic [CNT_W-1:0]        cnt_q;

	// pending result and output register
	logic [IDX_W-1:0] res_idx_q;
	logic             res_new_q;
	logic             res_full_q;
	logic             out_valid_q;
	logic [IDX_W-1:0] out_idx_q;
	logic             out_new_q;
	logic             out_full_q;

	// ram ports
	logic               head_we;
	logic [SLOT_W-1:0]  head_waddr;
	ptr_t               head_wdata;
	ptr_t               head_rdata;
	logic               link_we;
	logic [IDX_W-1:0]   link_waddr;
	ptr_t               link_wdata;
	ptr_t               link_rdata;
	logic               fld_we;
	logic [FADDR_W-1:0] fld_waddr;
	logic [FLD_W-1:0]   fld_rdata;

	logic                    in_xact;
	logic                    out_free;
	logic [SC_W-1:0]         n_eff;
	logic signed [SUM_W-1:0] sum_abs;
	logic [SC_W:0]           trial;
	logic signed [FLD_W:0]   diff;
	logic [FLD_W:0]          adiff;
	logic                    fld_ok;

	assign s_tready  = (state_q == S_IDLE);
	assign in_xact   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = 16'(out_idx_q);
	assign m_tuser  = {out_full_q, out_new_q};

	// zero slot count acts as one, above the store size saturates
	always_comb begin
		if (slot_count_q == '0) begin
			n_eff = SC_W'(1);
		end else if (slot_count_q > SC_W'(MAX_SLOTS)) begin
			n_eff = SC_W'(MAX_SLOTS);
		end else begin
			n_eff = slot_count_q;
		end
	end

	// magnitude of the key sum; shifting it equals truncate-then-abs
	assign sum_abs = acc_q[SUM_W-1] ? -acc_q : acc_q;
	// one restoring modulo step
	assign trial = {1'b0, rem_q, mag_q[MAG_W-1]};

	// shared field compare unit
	assign diff   = {fld_rdata[FLD_W-1], fld_rdata} - {fld_q[k_q][FLD_W-1], fld_q[k_q]};
	assign adiff  = diff[FLD_W] ? FLD_W'(0) - diff : diff;
	assign fld_ok = adiff < (FLD_W+1)'(tol_q);

	// ram write muxing
	always_comb begin
		head_we    = 1'b0;
		head_waddr = rem_q;
		head_wdata = '0;
		link_we    = 1'b0;
		link_waddr = cnt_q[IDX_W-1:0];
		link_wdata = '0;
		fld_we     = 1'b0;
		fld_waddr  = {cnt_q[IDX_W-1:0], k_q};
		unique case (state_q)
			S_CLEAR: begin
				head_we    = 1'b1;
				head_waddr = clr_q;
			end
			S_WFLD: begin
				fld_we = 1'b1;
			end
			S_WLNK: begin
				link_we = 1'b1;
			end
			S_WTAIL: begin
				head_wdata.valid = 1'b1;
				head_wdata.idx   = cnt_q[IDX_W-1:0];
				link_wdata       = head_wdata;
				link_waddr       = tail_q;
				link_we          = have_tail_q;
				head_we          = !have_tail_q;
			end
			default: begin
			end
		endcase
	end

	vdh_ram #(.WIDTH($bits(ptr_t)), .DEPTH(MAX_SLOTS)) u_heads (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_waddr),
		.wdata (head_wdata),
		.raddr (rem_q),
		.rdata (head_rdata)
	);

	vdh_ram #(.WIDTH($bits(ptr_t)), .DEPTH(MAX_ENTRIES)) u_links (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (cur_q),
		.rdata (link_rdata)
	);

	vdh_ram #(.WIDTH(FLD_W), .DEPTH(MAX_ENTRIES*NUM_FIELDS)) u_fields (
		.clk   (clk),
		.we    (fld_we),
		.waddr (fld_waddr),
		.wdata (fld_q[k_q]),
		.raddr ({cur_q, k_q}),
		.rdata (fld_rdata)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= SLOT_COUNT_RST;
			tol_q        <= TOLERANCE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_SLOT_COUNT: slot_count_q <= cfg_data[SC_W-1:0];
				CFG_TOLERANCE:  tol_q        <= cfg_data[TOL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// input vertex capture, payload only
	always_ff @(posedge clk) begin
		if (in_xact) begin
			for (int i = 0; i < NUM_FIELDS; i++) begin
				fld_q[i] <= s_tdata[i*FLD_W +: FLD_W];
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			k_q         <= '0;
			dc_q        <= '0;
			have_tail_q <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
			mag_q       <= '0;
			rem_q       <= '0;
			cur_q       <= '0;
			tail_q      <= '0;
			res_idx_q   <= '0;
			res_new_q   <= 1'b0;
			res_full_q  <= 1'b0;
			out_idx_q   <= '0;
			out_new_q   <= 1'b0;
			out_full_q  <= 1'b0;
		end else begin
			// result register loads on handoff, empties on acceptance
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SLOT_W'(MAX_SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_xact) begin
						acc_q       <= '0;
						k_q         <= '0;
						have_tail_q <= 1'b0;
						state_q     <= S_KEY;
					end
				end
				// one weighted term per cycle
				S_KEY: begin
					acc_q <= acc_q + key_term(fld_q[key_field(k_q)], k_q);
					k_q   <= k_q + 1'b1;
					if (k_q == K_W'(KEY_TERMS - 1)) begin
						state_q <= S_ABS;
					end
				end
				S_ABS: begin
					mag_q   <= sum_abs[SUM_W-1:FRAC_BITS];
					rem_q   <= '0;
					dc_q    <= '0;
					state_q <= S_DIV;
				end
				// one quotient bit per cycle, remainder kept
				S_DIV: begin
					if (trial >= (SC_W+1)'(n_eff)) begin
						rem_q <= SLOT_W'(trial - (SC_W+1)'(n_eff));
					end else begin
						rem_q <= SLOT_W'(trial);
					end
					mag_q <= mag_q << 1;
					dc_q  <= dc_q + 1'b1;
					if (dc_q == DIV_W'(MAG_W - 1)) begin
						state_q <= S_HRD;
					end
				end
				S_HRD: begin
					state_q <= S_HWT;
				end
				S_HWT: begin
					k_q <= '0;
					if (head_rdata.valid) begin
						cur_q   <= head_rdata.idx;
						state_q <= S_FRD;
					end else begin
						state_q <= S_APP;
					end
				end
				S_FRD: begin
					state_q <= S_FCMP;
				end
				S_FCMP: begin
					if (!fld_ok) begin
						have_tail_q <= 1'b1;
						tail_q      <= cur_q;
						state_q     <= S_LRD;
					end else if (k_q == K_W'(NUM_FIELDS - 1)) begin
						res_idx_q  <= cur_q;
						res_new_q  <= 1'b0;
						res_full_q <= 1'b0;
						state_q    <= S_DONE;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_FRD;
					end
				end
				S_LRD: begin
					state_q <= S_LWT;
				end
				S_LWT: begin
					k_q <= '0;
					if (link_rdata.valid) begin
						cur_q   <= link_rdata.idx;
						state_q <= S_FRD;
					end else begin
						state_q <= S_APP;
					end
				end
				S_APP: begin
					k_q <= '0;
					if (cnt_q >= CNT_W'(MAX_ENTRIES)) begin
						res_idx_q  <= '0;
						res_new_q  <= 1'b0;
						res_full_q <= 1'b1;
						state_q    <= S_DONE;
					end else begin
						state_q <= S_WFLD;
					end
				end
				S_WFLD: begin
					k_q <= k_q + 1'b1;
					if (k_q == K_W'(NUM_FIELDS - 1)) begin
						state_q <= S_WLNK;
					end
				end
				S_WLNK: begin
					state_q <= S_WTAIL;
				end
				S_WTAIL: begin
					res_idx_q  <= cnt_q[IDX_W-1:0];
					res_new_q  <= 1'b1;
					res_full_q <= 1'b0;
					cnt_q      <= cnt_q + 1'b1;
					state_q    <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_idx_q  <= res_idx_q;
						out_new_q  <= res_new_q;
						out_full_q <= res_full_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a taken vertex closes the input until its result is out
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a vertex is in flight");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_ENTRIES))
		else $error("stored count beyond capacity");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("result both new and full");

	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		fld_we |-> (cnt_q < CNT_W'(MAX_ENTRIES)))
		else $error("field write into a full store");

	a_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != $past(cnt_q) |-> $past(state_q) == S_WTAIL)
		else $error("stored count moved outside an append");
endmodule
